FILE: rtl/core/occg_pkg.sv
// ----------------------------------------------------------------------------
// occg_pkg
// Shared types and codes for the occupancy grid nearest search block.
// ----------------------------------------------------------------------------
package occg_pkg;

   // one grid cell: signed log-odds, below zero means occupied
   localparam int CELL_W = 8;
   typedef logic signed [CELL_W-1:0] cell_type;

   // request operation codes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_UPDATE = 2'd0;
   localparam opcode_type OP_SEARCH = 2'd1;
   localparam opcode_type OP_FILL   = 2'd2;

   // configuration register indexes and values
   typedef logic [0:0] csr_index_type;
   typedef logic [8:0] csr_data_type;
   localparam csr_index_type CSR_WIDTH  = 1'b0;
   localparam csr_index_type CSR_HEIGHT = 1'b1;
   localparam csr_data_type  SIZE_RESET = 9'd256;

endpackage

FILE: rtl/core/occg_ram.sv
// ----------------------------------------------------------------------------
// occg_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module occg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

FILE: rtl/core/occupancy_grid_nearest_search_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_nearest_search_top
// Log-odds occupancy grid held in one RAM, with update, fill and a ring-wise
// nearest occupied cell search.
// ----------------------------------------------------------------------------
// Usage
//   req_* words carry one operation: update (add log_odds to one cell with
//   saturation), fill (write log_odds to every cell) or search (find up to
//   wanted_count occupied cells ring by ring around the query cell).
//   A search returns one or more rsp_* words, the final one flagged by
//   rsp_last; update and fill return nothing. csr_* writes the grid size in
//   use. The user must write it only while idle; the block does not check.
// Timing
//   One request is processed at a time; req_stall is high while busy.
//   An update reads, modifies and writes the cell through the single RAM port.
//   Fill writes every one of the GRID_W*GRID_H cells, one cell per cycle.
//   A search scans each ring once per cell reported from it plus once more
//   unless the wanted count is reached there, with one RAM read per scanned
//   cell; the RAM port bounds the rate.
// Reset
//   After reset the block sweeps all GRID_W*GRID_H RAM cells to zero with
//   req_stall high. A stalled rsp word is held; the search waits for room.
// ----------------------------------------------------------------------------
module occupancy_grid_nearest_search_top #(
   parameter int GRID_W        = 256,
   parameter int GRID_H        = 256,
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  occg_pkg::opcode_type    req_opcode,
   input  logic signed [15:0]      req_cell_x,
   input  logic signed [15:0]      req_cell_y,
   input  occg_pkg::cell_type      req_log_odds,
   input  logic [4:0]              req_wanted_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic [7:0]              rsp_hit_x,
   output logic [7:0]              rsp_hit_y,
   output logic [16:0]             rsp_dist_sqr_cells,
   output logic [15:0]             rsp_cell_index,
   output logic                    rsp_last,
   input  logic                    csr_wr_en,
   input  occg_pkg::csr_index_type csr_index,
   input  occg_pkg::csr_data_type  csr_wdata
);

   import occg_pkg::*;

   localparam int GMAX  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
   localparam int CW    = $clog2(GMAX);
   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = 2 * CW + 1;
   localparam int LW    = 2 * CW + 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_RING,
      ST_SCAN, ST_DRAIN, ST_PICK, ST_FIN
   } state_type;

   state_type       state_ff;
   csr_data_type    width_ff, height_ff;
   logic [AW-1:0]   clr_ff;
   cell_type        fill_ff, upd_val_ff;
   logic [CW-1:0]   ux_ff, uy_ff, qx_ff, qy_ff;
   logic [4:0]      want_ff, count_ff;
   logic [CW:0]     r_ff;
   logic [CW-1:0]   cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic            phase_b_ff, sub_ff;
   logic [CW-1:0]   ctr_ff;
   logic            lim_ff;
   logic [DW-1:0]   prev_ff;
   logic            pick_have_ff;
   logic [DW-1:0]   pick_d_ff;
   logic [CW-1:0]   pick_x_ff, pick_y_ff;
   logic            pend_have_ff;
   logic [DW-1:0]   pend_d_ff;
   logic [CW-1:0]   pend_x_ff, pend_y_ff;
   logic [15:0]     pend_idx_ff;
   logic            ev_valid_ff;
   logic [CW-1:0]   ev_x_ff, ev_y_ff;
   logic            out_valid_ff, out_found_ff, out_last_ff;
   logic [7:0]      out_x_ff, out_y_ff;
   logic [16:0]     out_d_ff;
   logic [15:0]     out_idx_ff;

   // effective grid size: zero acts as one, clipped to the array
   logic [CW:0] w_c, h_c, maxr_c;
   always_comb begin
      if (width_ff == '0) w_c = (CW+1)'(1);
      else if (32'(width_ff) > GRID_W) w_c = (CW+1)'(GRID_W);
      else w_c = (CW+1)'(width_ff);
      if (height_ff == '0) h_c = (CW+1)'(1);
      else if (32'(height_ff) > GRID_H) h_c = (CW+1)'(GRID_H);
      else h_c = (CW+1)'(height_ff);
      maxr_c = (w_c > h_c) ? w_c : h_c;
   end

   // request decode: clamp query, check update bounds, limit wanted count
   logic [CW-1:0] qx_c, qy_c;
   logic          on_grid_c;
   logic [4:0]    want_c;
   always_comb begin
      if (req_cell_x[15]) qx_c = '0;
      else if (32'(req_cell_x[14:0]) >= 32'(w_c)) qx_c = CW'(w_c - 1'b1);
      else qx_c = CW'(req_cell_x[14:0]);
      if (req_cell_y[15]) qy_c = '0;
      else if (32'(req_cell_y[14:0]) >= 32'(h_c)) qy_c = CW'(h_c - 1'b1);
      else qy_c = CW'(req_cell_y[14:0]);
      on_grid_c = !req_cell_x[15] && !req_cell_y[15]
                  && (32'(req_cell_x[14:0]) < 32'(w_c))
                  && (32'(req_cell_y[14:0]) < 32'(h_c));
      if (32'(req_wanted_count) > MAX_NEIGHBORS) want_c = 5'(MAX_NEIGHBORS);
      else want_c = req_wanted_count;
   end

   // ring bounds clamped to the grid
   logic [CW+1:0] lo_x, hi_x, lo_y, hi_y;
   logic [CW-1:0] cx0_c, cx1_c, cy0_c, cy1_c;
   always_comb begin
      lo_x = {2'b00, qx_ff} - {1'b0, r_ff};
      hi_x = {2'b00, qx_ff} + {1'b0, r_ff};
      lo_y = {2'b00, qy_ff} - {1'b0, r_ff};
      hi_y = {2'b00, qy_ff} + {1'b0, r_ff};
      cx0_c = lo_x[CW+1] ? '0 : lo_x[CW-1:0];
      cy0_c = lo_y[CW+1] ? '0 : lo_y[CW-1:0];
      cx1_c = (hi_x >= {1'b0, w_c}) ? CW'(w_c - 1'b1) : hi_x[CW-1:0];
      cy1_c = (hi_y >= {1'b0, h_c}) ? CW'(h_c - 1'b1) : hi_y[CW-1:0];
   end

   // scan position: top and bottom rows first, then the side columns
   logic [CW-1:0] sx_c, sy_c;
   logic          rows_apart_c, has_sides_c;
   always_comb begin
      rows_apart_c = (cy1_ff != cy0_ff);
      has_sides_c  = ({1'b0, cy1_ff} > ({1'b0, cy0_ff} + 1'b1));
      if (!phase_b_ff) begin
         sx_c = ctr_ff;
         sy_c = sub_ff ? cy1_ff : cy0_ff;
      end else begin
         sx_c = sub_ff ? cx1_ff : cx0_ff;
         sy_c = ctr_ff;
      end
   end

   // shared linear index: column plus row times width
   logic [CW-1:0] ax_c, ay_c;
   logic [LW-1:0] lin_c;
   always_comb begin
      case (state_ff)
         ST_SCAN: begin
            ax_c = sx_c;
            ay_c = sy_c;
         end
         ST_PICK: begin
            ax_c = pick_x_ff;
            ay_c = pick_y_ff;
         end
         default: begin
            ax_c = ux_ff;
            ay_c = uy_ff;
         end
      endcase
      lin_c = ({{(CW+1){1'b0}}, ay_c} * {{CW{1'b0}}, w_c})
              + {{(CW+1){1'b0}}, ax_c};
   end

   // RAM port
   logic          ram_en, ram_we;
   logic [AW-1:0] ram_addr;
   cell_type      ram_wdata, ram_rdata;
   logic [CELL_W:0] upd_sum;
   cell_type      upd_sat;

   always_comb begin
      upd_sum = {ram_rdata[CELL_W-1], ram_rdata} + {upd_val_ff[CELL_W-1], upd_val_ff};
      if (upd_sum[CELL_W] != upd_sum[CELL_W-1]) begin
         upd_sat = upd_sum[CELL_W] ? cell_type'(8'h80) : cell_type'(8'h7f);
      end else begin
         upd_sat = upd_sum[CELL_W-1:0];
      end
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = AW'(lin_c);
      ram_wdata = upd_sat;
      case (state_ff)
         ST_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = fill_ff;
         end
         ST_UPD_RD, ST_SCAN: ram_en = 1'b1;
         ST_UPD_WR: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
         end
         default: ram_en = 1'b0;
      endcase
   end

   occg_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // evaluate the cell read last cycle
   logic [CW-1:0] dx_c, dy_c;
   logic [DW-1:0] d_c;
   logic          take_c;
   always_comb begin
      dx_c = (ev_x_ff >= qx_ff) ? ev_x_ff - qx_ff : qx_ff - ev_x_ff;
      dy_c = (ev_y_ff >= qy_ff) ? ev_y_ff - qy_ff : qy_ff - ev_y_ff;
      d_c  = DW'({{CW{1'b0}}, dx_c} * {{CW{1'b0}}, dx_c})
           + DW'({{CW{1'b0}}, dy_c} * {{CW{1'b0}}, dy_c});
      take_c = ev_valid_ff && ram_rdata[CELL_W-1]
               && !(lim_ff && (d_c <= prev_ff))
               && (!pick_have_ff || (d_c <= pick_d_ff));
   end

   logic accept_c, out_free_c, pass_end_c;
   assign accept_c   = req_valid && !req_stall;
   assign out_free_c = !out_valid_ff || !rsp_stall;
   assign pass_end_c = phase_b_ff ? (sub_ff && (ctr_ff == CW'(cy1_ff - 1'b1)))
                                  : ((sub_ff || !rows_apart_c) && (ctr_ff == cx1_ff)
                                     && !has_sides_c);

   // sequencer, search state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         clr_ff       <= '0;
         fill_ff      <= '0;
         ev_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pick_have_ff <= 1'b0;
         pend_have_ff <= 1'b0;
         count_ff     <= '0;
         want_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_WIDTH) width_ff <= csr_wdata;
            else height_ff <= csr_wdata;
         end
         if (!rsp_stall) out_valid_ff <= 1'b0;

         ev_valid_ff <= (state_ff == ST_SCAN);
         ev_x_ff     <= sx_c;
         ev_y_ff     <= sy_c;
         if (take_c) begin
            pick_have_ff <= 1'b1;
            pick_d_ff    <= d_c;
            pick_x_ff    <= ev_x_ff;
            pick_y_ff    <= ev_y_ff;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DEPTH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept_c) begin
                  ux_ff      <= CW'(req_cell_x[14:0]);
                  uy_ff      <= CW'(req_cell_y[14:0]);
                  upd_val_ff <= req_log_odds;
                  fill_ff    <= req_log_odds;
                  qx_ff      <= qx_c;
                  qy_ff      <= qy_c;
                  want_ff    <= want_c;
                  r_ff       <= '0;
                  count_ff   <= '0;
                  pend_have_ff <= 1'b0;
                  clr_ff     <= '0;
                  case (req_opcode)
                     OP_UPDATE: if (on_grid_c) state_ff <= ST_UPD_RD;
                     OP_FILL:   state_ff <= ST_CLEAR;
                     OP_SEARCH: state_ff <= (want_c == '0) ? ST_FIN : ST_RING;
                     default:   state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_UPD_RD: state_ff <= ST_UPD_WR;
            ST_UPD_WR: state_ff <= ST_IDLE;
            ST_RING: begin
               cx0_ff       <= cx0_c;
               cx1_ff       <= cx1_c;
               cy0_ff       <= cy0_c;
               cy1_ff       <= cy1_c;
               ctr_ff       <= cx0_c;
               phase_b_ff   <= 1'b0;
               sub_ff       <= 1'b0;
               lim_ff       <= 1'b0;
               prev_ff      <= '0;
               pick_have_ff <= 1'b0;
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               if (pass_end_c) begin
                  state_ff <= ST_DRAIN;
               end else if (!phase_b_ff) begin
                  if (sub_ff || !rows_apart_c) begin
                     sub_ff <= 1'b0;
                     if (ctr_ff == cx1_ff) begin
                        phase_b_ff <= 1'b1;
                        ctr_ff     <= CW'(cy0_ff + 1'b1);
                     end else begin
                        ctr_ff <= ctr_ff + 1'b1;
                     end
                  end else begin
                     sub_ff <= 1'b1;
                  end
               end else begin
                  sub_ff <= !sub_ff;
                  if (sub_ff) ctr_ff <= ctr_ff + 1'b1;
               end
            end
            ST_DRAIN: state_ff <= ST_PICK;
            ST_PICK: begin
               if (out_free_c) begin
                  if (pick_have_ff) begin
                     // hand on the held hit, keep the new one
                     if (pend_have_ff) begin
                        out_valid_ff <= 1'b1;
                        out_found_ff <= 1'b1;
                        out_x_ff     <= 8'(pend_x_ff);
                        out_y_ff     <= 8'(pend_y_ff);
                        out_d_ff     <= 17'(pend_d_ff);
                        out_idx_ff   <= pend_idx_ff;
                        out_last_ff  <= 1'b0;
                     end
                     pend_have_ff <= 1'b1;
                     pend_x_ff    <= pick_x_ff;
                     pend_y_ff    <= pick_y_ff;
                     pend_d_ff    <= pick_d_ff;
                     pend_idx_ff  <= 16'(lin_c);
                     count_ff     <= count_ff + 1'b1;
                     if (5'(count_ff + 1'b1) == want_ff) begin
                        state_ff <= ST_FIN;
                     end else begin
                        lim_ff       <= 1'b1;
                        prev_ff      <= pick_d_ff;
                        ctr_ff       <= cx0_ff;
                        phase_b_ff   <= 1'b0;
                        sub_ff       <= 1'b0;
                        pick_have_ff <= 1'b0;
                        state_ff     <= ST_SCAN;
                     end
                  end else if ((CW+1)'(r_ff + 1'b1) == maxr_c) begin
                     state_ff <= ST_FIN;
                  end else begin
                     r_ff     <= r_ff + 1'b1;
                     state_ff <= ST_RING;
                  end
               end
            end
            ST_FIN: begin
               if (out_free_c) begin
                  out_valid_ff <= 1'b1;
                  out_found_ff <= pend_have_ff;
                  out_x_ff     <= pend_have_ff ? 8'(pend_x_ff) : '0;
                  out_y_ff     <= pend_have_ff ? 8'(pend_y_ff) : '0;
                  out_d_ff     <= pend_have_ff ? 17'(pend_d_ff) : '0;
                  out_idx_ff   <= pend_have_ff ? pend_idx_ff : '0;
                  out_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_hit_x          = out_x_ff;
   assign rsp_hit_y          = out_y_ff;
   assign rsp_dist_sqr_cells = out_d_ff;
   assign rsp_cell_index     = out_idx_ff;
   assign rsp_last           = out_last_ff;

   // never report more hits than wanted
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= want_ff)
      else $error("hit count above wanted count");

   // no RAM write while a ring is being scanned
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("RAM write during scan");

   // the final word of a search returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free_c) |=> (state_ff == ST_IDLE && rsp_last && rsp_valid))
      else $error("final word without return to idle");

   // a pass ends with the last cell still to be evaluated
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> ev_valid_ff)
      else $error("drain without pending cell");

endmodule
